// File: rtl/core/kaa_pkg.sv
// Shared types, constants and helpers for the k-means assign/accumulate block.
// No dependencies; used by kaa_ctrl, kaa_dp and the top level.
package kaa_pkg;

  localparam int MaxCentroids = 16;
  localparam int MaxDims      = 16;

  localparam int KW     = $clog2(MaxCentroids);
  localparam int DW     = (MaxDims > 1) ? $clog2(MaxDims) : 1;
  localparam int Depth  = MaxCentroids * MaxDims;
  localparam int AW     = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntKW  = $clog2(MaxCentroids + 1);
  localparam int CntDW  = $clog2(MaxDims + 1);
  localparam int ProdW  = 34;
  localparam int ScoreW = ProdW + DW + 1;

  localparam int DrainCycles = 4;
  localparam int DivSteps    = 32;
  localparam int StepW       = $clog2(DivSteps + 1);

  localparam int CfgIdxW = 3;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_POINT = 2'd1,
    MODE_READ  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NK     = 3'd0,
    CFG_ND     = 3'd1,
    CFG_GATE   = 3'd2,
    CFG_LIMIT  = 3'd3,
    CFG_OFFSET = 3'd4
  } cfg_e;

  typedef enum logic {
    KIND_ASSIGN   = 1'b0,
    KIND_CENTROID = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCORE,
    ST_SDRAIN,
    ST_GATE,
    ST_GDRAIN,
    ST_DECIDE,
    ST_ACCUM,
    ST_ACCUM_END,
    ST_DIV_RD,
    ST_DIV_LD,
    ST_DIV_RUN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic          accept;
    logic          score_en;
    logic          score_first;
    logic          score_last;
    logic          gate_en;
    logic          decide;
    logic          accum_en;
    logic          accum_end;
    logic          div_rd;
    logic          div_ld;
    logic          div_step;
    logic          emit;
    logic [KW-1:0] k;
    logic [DW-1:0] d;
  } cmd_t;

  typedef struct packed {
    logic [CntKW-1:0] nk;
    logic [CntDW-1:0] nd;
    logic             gate_needed;
    logic             oor_now;
    logic             out_free;
  } sts_t;

  function automatic logic [AW-1:0] tab_addr(logic [KW-1:0] k, logic [DW-1:0] d);
    tab_addr = AW'(k) * AW'(MaxDims) + AW'(d);
  endfunction

endpackage

// File: rtl/core/kaa_ctrl.sv
// Sequencer for the k-means block: walks score, gate, accumulate and divide phases.
// Depends on kaa_pkg; drives kaa_dp through cmd_t, watches sts_t.
module kaa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_mode_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  kaa_pkg::sts_t     sts_i,
  output kaa_pkg::cmd_t     cmd_o
);

  kaa_pkg::state_e            state_q, state_d;
  logic [kaa_pkg::KW-1:0]     k_q, k_d;
  logic [kaa_pkg::DW-1:0]     d_q, d_d;
  logic [kaa_pkg::StepW-1:0]  cnt_q, cnt_d;
  logic                       k_end, d_end;

  assign k_end = (k_q == kaa_pkg::KW'(sts_i.nk - 1'b1));
  assign d_end = (d_q == kaa_pkg::DW'(sts_i.nd - 1'b1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kaa_pkg::ST_IDLE;
      k_q     <= '0;
      d_q     <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      d_q     <= d_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    d_d        = d_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.k    = k_q;
    cmd_o.d    = d_q;
    unique case (state_q)
      kaa_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        k_d        = '0;
        d_d        = '0;
        cnt_d      = '0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (kaa_pkg::mode_e'(in_mode_i))
            kaa_pkg::MODE_POINT: if (in_last_i) state_d = kaa_pkg::ST_SCORE;
            kaa_pkg::MODE_READ:  state_d = kaa_pkg::ST_DIV_RD;
            default:             state_d = kaa_pkg::ST_IDLE;
          endcase
        end
      end
      kaa_pkg::ST_SCORE: begin
        cmd_o.score_en    = 1'b1;
        cmd_o.score_first = (d_q == '0);
        cmd_o.score_last  = d_end;
        if (d_end) begin
          d_d = '0;
          if (k_end) state_d = kaa_pkg::ST_SDRAIN;
          else k_d = k_q + 1'b1;
        end else begin
          d_d = d_q + 1'b1;
        end
      end
      kaa_pkg::ST_SDRAIN, kaa_pkg::ST_GDRAIN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == kaa_pkg::StepW'(kaa_pkg::DrainCycles - 1)) begin
          cnt_d = '0;
          if (state_q == kaa_pkg::ST_SDRAIN && sts_i.gate_needed) state_d = kaa_pkg::ST_GATE;
          else state_d = kaa_pkg::ST_DECIDE;
        end
      end
      kaa_pkg::ST_GATE: begin
        cmd_o.gate_en = 1'b1;
        d_d = d_q + 1'b1;
        if (d_end) begin
          d_d     = '0;
          state_d = kaa_pkg::ST_GDRAIN;
        end
      end
      kaa_pkg::ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        d_d          = '0;
        state_d      = sts_i.oor_now ? kaa_pkg::ST_EMIT : kaa_pkg::ST_ACCUM;
      end
      kaa_pkg::ST_ACCUM: begin
        cmd_o.accum_en = 1'b1;
        d_d = d_q + 1'b1;
        if (d_end) begin
          d_d     = '0;
          state_d = kaa_pkg::ST_ACCUM_END;
        end
      end
      kaa_pkg::ST_ACCUM_END: begin
        cmd_o.accum_end = 1'b1;
        state_d         = kaa_pkg::ST_EMIT;
      end
      kaa_pkg::ST_DIV_RD: begin
        cmd_o.div_rd = 1'b1;
        state_d      = kaa_pkg::ST_DIV_LD;
      end
      kaa_pkg::ST_DIV_LD: begin
        cmd_o.div_ld = 1'b1;
        cnt_d        = '0;
        state_d      = kaa_pkg::ST_DIV_RUN;
      end
      kaa_pkg::ST_DIV_RUN: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == kaa_pkg::StepW'(kaa_pkg::DivSteps - 1)) begin
          cnt_d   = '0;
          state_d = kaa_pkg::ST_EMIT;
        end
      end
      kaa_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = kaa_pkg::ST_IDLE;
        end
      end
      default: state_d = kaa_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: rtl/core/kaa_dp.sv
// Datapath: centroid table, point buffer, sums memory, counts, score pipe, divider.
// Depends on kaa_pkg; steered by kaa_ctrl through cmd_t.
module kaa_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kaa_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [15:0]                       cfg_data_i,
  input  logic [1:0]                        in_mode_i,
  input  logic [3:0]                        in_ci_i,
  input  logic [3:0]                        in_di_i,
  input  logic signed [15:0]                in_val_i,
  input  logic [15:0]                       in_cur_i,
  input  kaa_pkg::cmd_t                     cmd_i,
  output kaa_pkg::sts_t                     sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              out_kind_o,
  output logic [15:0]                       out_asg_o,
  output logic                              out_changed_o,
  output logic [15:0]                       out_total_o,
  output logic                              out_oor_o,
  output logic signed [15:0]                out_cval_o
);

  // configuration
  logic [4:0]  cfg_nk_q, cfg_nd_q;
  logic        cfg_gate_q;
  logic [15:0] cfg_limit_q, cfg_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_nk_q    <= 5'd16;
      cfg_nd_q    <= 5'd16;
      cfg_gate_q  <= 1'b0;
      cfg_limit_q <= 16'hFFFF;
      cfg_off_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (kaa_pkg::cfg_e'(cfg_idx_i))
        kaa_pkg::CFG_NK:     cfg_nk_q    <= cfg_data_i[4:0];
        kaa_pkg::CFG_ND:     cfg_nd_q    <= cfg_data_i[4:0];
        kaa_pkg::CFG_GATE:   cfg_gate_q  <= cfg_data_i[0];
        kaa_pkg::CFG_LIMIT:  cfg_limit_q <= cfg_data_i;
        kaa_pkg::CFG_OFFSET: cfg_off_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [kaa_pkg::CntKW-1:0] nk;
  logic [kaa_pkg::CntDW-1:0] nd;
  assign nk = (cfg_nk_q == '0) ? kaa_pkg::CntKW'(1) :
              (int'(cfg_nk_q) > kaa_pkg::MaxCentroids) ? kaa_pkg::CntKW'(kaa_pkg::MaxCentroids) :
              kaa_pkg::CntKW'(cfg_nk_q);
  assign nd = (cfg_nd_q == '0) ? kaa_pkg::CntDW'(1) :
              (int'(cfg_nd_q) > kaa_pkg::MaxDims) ? kaa_pkg::CntDW'(kaa_pkg::MaxDims) :
              kaa_pkg::CntDW'(cfg_nd_q);

  // captured item
  logic                    is_load, is_point, is_clear, ci_ok, di_ok;
  logic [kaa_pkg::KW-1:0]  in_k;
  logic [kaa_pkg::DW-1:0]  in_d;
  logic                    kind_q, rd_ok_q;
  logic [kaa_pkg::AW-1:0]  rd_addr_q;
  logic [kaa_pkg::KW-1:0]  rd_k_q;
  logic [15:0]             cur_q;

  assign is_load  = cmd_i.accept && (kaa_pkg::mode_e'(in_mode_i) == kaa_pkg::MODE_LOAD);
  assign is_point = cmd_i.accept && (kaa_pkg::mode_e'(in_mode_i) == kaa_pkg::MODE_POINT);
  assign is_clear = cmd_i.accept && (kaa_pkg::mode_e'(in_mode_i) == kaa_pkg::MODE_CLEAR);
  assign ci_ok    = (int'(in_ci_i) < kaa_pkg::MaxCentroids);
  assign di_ok    = (int'(in_di_i) < kaa_pkg::MaxDims);
  assign in_k     = kaa_pkg::KW'(in_ci_i);
  assign in_d     = kaa_pkg::DW'(in_di_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q    <= (kaa_pkg::mode_e'(in_mode_i) == kaa_pkg::MODE_READ);
      rd_ok_q   <= ci_ok && di_ok;
      rd_addr_q <= kaa_pkg::tab_addr(in_k, in_d);
      rd_k_q    <= in_k;
      cur_q     <= in_cur_i;
    end
  end

  // point buffer
  logic signed [15:0] pb_q [kaa_pkg::MaxDims];
  logic signed [15:0] pb_rd;
  assign pb_rd = pb_q[cmd_i.d];

  always_ff @(posedge clk_i) begin
    if (is_point && di_ok) pb_q[in_d] <= in_val_i;
  end

  // centroid table
  logic signed [15:0]     ctab [kaa_pkg::Depth];
  logic signed [15:0]     c_rd_q;
  logic [kaa_pkg::KW-1:0] best_k_q;
  logic [kaa_pkg::AW-1:0] c_ra;

  assign c_ra = kaa_pkg::tab_addr(cmd_i.gate_en ? best_k_q : cmd_i.k, cmd_i.d);

  always_ff @(posedge clk_i) begin
    if (is_load && ci_ok && di_ok) ctab[kaa_pkg::tab_addr(in_k, in_d)] <= in_val_i;
    c_rd_q <= ctab[c_ra];
  end

  // score and gate pipeline
  logic                          s1_v_q, s1_g_q, s1_first_q, s1_last_q;
  logic [kaa_pkg::KW-1:0]        s1_k_q;
  logic signed [15:0]            a1_q;
  logic                          s2_v_q, s2_g_q, s2_first_q, s2_last_q;
  logic [kaa_pkg::KW-1:0]        s2_k_q;
  logic signed [kaa_pkg::ProdW-1:0] prod_q;
  logic [16:0]                   ad_q;
  logic                          s3_v_q;
  logic [kaa_pkg::KW-1:0]        s3_k_q;
  logic signed [kaa_pkg::ScoreW-1:0] acc_q, best_q;
  logic [16:0]                   mx_q;
  logic signed [17:0]            c_term;
  logic signed [16:0]            diff;

  // c*c - 2*c*a folded into c*(c - 2a)
  assign c_term = 18'(c_rd_q) - (18'(a1_q) <<< 1);
  assign diff   = 17'(c_rd_q) - 17'(a1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s1_g_q <= 1'b0;
      s2_v_q <= 1'b0;
      s2_g_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.score_en;
      s1_g_q <= cmd_i.gate_en;
      s2_v_q <= s1_v_q;
      s2_g_q <= s1_g_q;
      s3_v_q <= s2_v_q && s2_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_first_q <= cmd_i.score_first;
    s1_last_q  <= cmd_i.score_last;
    s1_k_q     <= cmd_i.k;
    a1_q       <= pb_rd;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_k_q     <= s1_k_q;
    prod_q     <= 34'(c_rd_q * c_term);
    ad_q       <= diff[16] ? 17'(-diff) : 17'(diff);
    s3_k_q     <= s2_k_q;
    if (s2_v_q) acc_q <= (s2_first_q ? '0 : acc_q) + kaa_pkg::ScoreW'(prod_q);
    if (s3_v_q && (s3_k_q == '0 || acc_q < best_q)) begin
      best_q   <= acc_q;
      best_k_q <= s3_k_q;
    end
    if (cmd_i.accept) mx_q <= '0;
    else if (s2_g_q && ad_q > mx_q) mx_q <= ad_q;
  end

  // reassignment decision
  logic [15:0]            tent, fin, loc;
  logic                   differs, take, changed, oor;
  logic                   changed_q, oor_q;
  logic [15:0]            fin_q, total_q;
  logic [kaa_pkg::KW-1:0] loc_q;

  assign tent    = 16'(best_k_q) + cfg_off_q;
  assign differs = (tent != cur_q);
  assign take    = !cfg_gate_q || (mx_q <= 17'(cfg_limit_q));
  assign changed = differs && take;
  assign fin     = changed ? tent : cur_q;
  assign loc     = fin - cfg_off_q;
  assign oor     = (32'(loc) >= 32'(nk));

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      changed_q <= changed;
      oor_q     <= oor;
      fin_q     <= fin;
      loc_q     <= kaa_pkg::KW'(loc);
    end
  end

  // sums memory with per-entry valid bits, member counts, reassign total
  logic signed [31:0]     sums [kaa_pkg::Depth];
  logic [kaa_pkg::Depth-1:0] svld_q;
  logic [15:0]            cnt_q [kaa_pkg::MaxCentroids];
  logic [kaa_pkg::AW-1:0] s_ra, acc_wa_q;
  logic signed [31:0]     s_rd_q, s_eff, s_new;
  logic                   s_vld_rd_q, acc_v_q;
  logic signed [15:0]     acc_a_q;
  logic signed [32:0]     s_sum;

  assign s_ra  = cmd_i.div_rd ? rd_addr_q : kaa_pkg::tab_addr(loc_q, cmd_i.d);
  assign s_eff = s_vld_rd_q ? s_rd_q : 32'sd0;
  assign s_sum = 33'(s_eff) + 33'(acc_a_q);
  assign s_new = (s_sum[32] != s_sum[31]) ? (s_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                          : s_sum[31:0];

  always_ff @(posedge clk_i) begin
    if (acc_v_q) sums[acc_wa_q] <= s_new;
    s_rd_q   <= sums[s_ra];
    acc_wa_q <= s_ra;
    acc_a_q  <= pb_rd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      svld_q     <= '0;
      s_vld_rd_q <= 1'b0;
      acc_v_q    <= 1'b0;
      total_q    <= '0;
      for (int i = 0; i < kaa_pkg::MaxCentroids; i++) cnt_q[i] <= '0;
    end else begin
      s_vld_rd_q <= svld_q[s_ra];
      acc_v_q    <= cmd_i.accum_en;
      if (is_clear) begin
        svld_q  <= '0;
        total_q <= '0;
        for (int i = 0; i < kaa_pkg::MaxCentroids; i++) cnt_q[i] <= '0;
      end else begin
        if (acc_v_q) svld_q[acc_wa_q] <= 1'b1;
        if (cmd_i.accum_end && cnt_q[loc_q] != 16'hFFFF) cnt_q[loc_q] <= cnt_q[loc_q] + 1'b1;
        if (cmd_i.decide && changed && total_q != 16'hFFFF) total_q <= total_q + 1'b1;
      end
    end
  end

  // restoring divider, one quotient bit per step
  logic [15:0]        dvs_q, rem_q;
  logic [31:0]        quo_q;
  logic               neg_q, zero_q;
  logic [15:0]        cnt_sel;
  logic [32:0]        mag;
  logic [17:0]        trial;
  logic               ge;
  logic signed [15:0] mean;

  assign cnt_sel = cnt_q[rd_k_q];
  assign mag     = s_eff[31] ? 33'(-33'(s_eff)) : 33'(s_eff);
  assign trial   = {1'b0, rem_q, quo_q[31]} - {2'b00, dvs_q};
  assign ge      = !trial[17];

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_ld) begin
      dvs_q  <= cnt_sel;
      rem_q  <= '0;
      quo_q  <= mag[31:0] + 32'(cnt_sel >> 1);
      neg_q  <= s_eff[31];
      zero_q <= (cnt_sel == '0) || !rd_ok_q;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? trial[15:0] : {rem_q[14:0], quo_q[31]};
      quo_q <= {quo_q[30:0], ge};
    end
  end

  always_comb begin
    if (zero_q)                    mean = 16'sd0;
    else if (!neg_q)               mean = (quo_q > 32'd32767) ? 16'sh7FFF : 16'(quo_q);
    else if (quo_q > 32'd32768)    mean = 16'sh8000;
    else                           mean = 16'(-quo_q);
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (cmd_i.emit) out_valid_o <= 1'b1;
    else if (out_ready_i) out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_o    <= kind_q ? kaa_pkg::KIND_CENTROID : kaa_pkg::KIND_ASSIGN;
      out_asg_o     <= kind_q ? '0 : fin_q;
      out_changed_o <= !kind_q && changed_q;
      out_total_o   <= kind_q ? '0 : total_q;
      out_oor_o     <= !kind_q && oor_q;
      out_cval_o    <= kind_q ? mean : '0;
    end
  end

  assign sts_o.nk          = nk;
  assign sts_o.nd          = nd;
  assign sts_o.gate_needed = cfg_gate_q && differs;
  assign sts_o.oor_now     = oor;
  assign sts_o.out_free    = !out_valid_o || out_ready_i;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_o || out_ready_i)) else $error("emit over pending beat");
  a_phase_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.score_en, cmd_i.gate_en, cmd_i.accum_en, cmd_i.div_step}))
    else $error("datapath phases overlap");
  a_oor_no_accum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.decide && oor) |=> !cmd_i.accum_en) else $error("accumulate on out-of-range label");

endmodule

// File: rtl/core/kmeans_assign_and_accumulate.sv
// Loads, clears and non-last coordinates are taken without leaving idle; the last coordinate of
//   a point starts a score walk over every centroid coordinate through one multiplier, a gate
//   walk when the gate is on and the label differs, and an accumulate walk that an
//   out-of-range final label skips.
// Read beats run through the 32-step restoring divider.
// One item at a time; a finished result waits in the output register while the next is taken.
// Reset (async, active low) clears sums valid bits, counts, reassign total and config to defaults.
module kmeans_assign_and_accumulate (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // centroid_index, coord_index, value, current_assignment
  input  logic [1:0]  s_axis_tuser_i,   // mode
  input  logic        s_axis_tlast_i,   // last_coord
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // assignment, changed, reassigned_total, out_of_range,
                                        // centroid_value, zero pad
  output logic        m_axis_tuser_o    // kind
);

  kaa_pkg::cmd_t cmd;
  kaa_pkg::sts_t sts;

  logic              kind;
  logic [15:0]       asg, total;
  logic              chg, oor;
  logic signed [15:0] cval;

  // sequencer owns the input handshake
  kaa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_mode_i  (s_axis_tuser_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kaa_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_mode_i     (s_axis_tuser_i),
    .in_ci_i       (s_axis_tdata_i[3:0]),
    .in_di_i       (s_axis_tdata_i[7:4]),
    .in_val_i      (s_axis_tdata_i[23:8]),
    .in_cur_i      (s_axis_tdata_i[39:24]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_kind_o    (kind),
    .out_asg_o     (asg),
    .out_changed_o (chg),
    .out_total_o   (total),
    .out_oor_o     (oor),
    .out_cval_o    (cval)
  );

  // pack result fields, lowest first
  assign m_axis_tdata_o = {6'b0, cval, oor, total, chg, asg};
  assign m_axis_tuser_o = kind;

endmodule
